@@ src/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, protocol constants and the CRC-8 DVB-S2 step for the
// stream frame parser.
// ----------------------------------------------------------------------------
package msp_pkg;

    // fixed field widths of a result word
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CODE_W = 16;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_V1     = 8'h4D;  // 'M'
    localparam logic [7:0] CH_V2     = 8'h58;  // 'X'

    // crc-8 dvb-s2
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // header of a checked frame, handed from the front end to the emitter
    typedef struct packed {
        logic              version;
        logic [7:0]        direction;
        logic [7:0]        flag;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } t_frame;

    // one crc step over a whole byte, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/msp_ram.sv @@
// ----------------------------------------------------------------------------
// msp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/msp_front.sv @@
// ----------------------------------------------------------------------------
// msp_front
// Byte-level frame recognizer: tracks the header, keeps the running check
// byte, stores the payload and posts a checked frame to the emitter.
// ----------------------------------------------------------------------------
module msp_front #(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_take,
    output msp_pkg::t_frame o_desc,
    output logic            o_desc_vld,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [7:0]      o_wdata
);
    import msp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE,
        ST_V1_DIR, ST_V1_LEN, ST_V1_CODE, ST_V1_PAY, ST_V1_CHK,
        ST_V2_DIR, ST_V2_FLAG, ST_V2_CLO, ST_V2_CHI, ST_V2_LLO, ST_V2_LHI,
        ST_V2_PAY, ST_V2_CHK
    } t_state;

    localparam logic [7:0]  MAX8  = 8'(MAX_PAYLOAD);
    localparam logic [15:0] MAX16 = 16'(MAX_PAYLOAD);

    t_state             r_state;
    logic               r_version;
    logic [7:0]         r_dir;
    logic [7:0]         r_flag;
    logic [CODE_W-1:0]  r_code;
    logic [7:0]         r_len_lo;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_count;
    logic [7:0]         r_check;
    logic               r_desc_vld;

    logic [7:0]         n_check;
    logic [LEN_W-1:0]   n_count;
    logic [15:0]        w_len16;
    logic               w_pay;

    // check byte update and payload counter
    assign n_check = r_version ? crc8_step(r_check, i_rx_byte) : (r_check ^ i_rx_byte);
    assign n_count = r_count + LEN_W'(1);
    assign w_len16 = {i_rx_byte, r_len_lo};
    assign w_pay   = (r_state == ST_V1_PAY) || (r_state == ST_V2_PAY);

    // payload buffer write
    assign o_we    = i_valid && w_pay;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_rx_byte;

    // parse state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_desc_vld <= 1'b0;
            r_version  <= 1'b0;
            r_check    <= 8'd0;
            r_count    <= '0;
        end else begin
            if (i_take) begin
                r_desc_vld <= 1'b0;
            end
            if (i_valid) begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (i_rx_byte == CH_DOLLAR) r_state <= ST_PRE;
                    end
                    ST_PRE: begin
                        r_check <= 8'd0;
                        if (i_rx_byte == CH_V1) begin
                            r_version <= 1'b0;
                            r_flag    <= 8'd0;
                            r_state   <= ST_V1_DIR;
                        end else if (i_rx_byte == CH_V2) begin
                            r_version <= 1'b1;
                            r_state   <= ST_V2_DIR;
                        end else begin
                            r_state   <= ST_IDLE;
                        end
                    end
                    ST_V1_DIR: begin
                        r_dir   <= i_rx_byte;
                        r_state <= ST_V1_LEN;
                    end
                    ST_V1_LEN: begin
                        r_len   <= i_rx_byte[LEN_W-1:0];
                        r_count <= '0;
                        r_check <= n_check;
                        r_state <= (i_rx_byte > MAX8) ? ST_IDLE : ST_V1_CODE;
                    end
                    ST_V1_CODE: begin
                        r_code  <= {8'd0, i_rx_byte};
                        r_check <= n_check;
                        r_state <= (r_len != '0) ? ST_V1_PAY : ST_V1_CHK;
                    end
                    ST_V2_DIR: begin
                        r_dir   <= i_rx_byte;
                        r_state <= ST_V2_FLAG;
                    end
                    ST_V2_FLAG: begin
                        r_flag  <= i_rx_byte;
                        r_check <= n_check;
                        r_state <= ST_V2_CLO;
                    end
                    ST_V2_CLO: begin
                        r_code  <= {8'd0, i_rx_byte};
                        r_check <= n_check;
                        r_state <= ST_V2_CHI;
                    end
                    ST_V2_CHI: begin
                        r_code  <= {i_rx_byte, r_code[7:0]};
                        r_check <= n_check;
                        r_state <= ST_V2_LLO;
                    end
                    ST_V2_LLO: begin
                        r_len_lo <= i_rx_byte;
                        r_check  <= n_check;
                        r_state  <= ST_V2_LHI;
                    end
                    ST_V2_LHI: begin
                        r_len   <= r_len_lo[LEN_W-1:0];
                        r_count <= '0;
                        r_check <= n_check;
                        if (w_len16 > MAX16) begin
                            r_state <= ST_IDLE;
                        end else if (w_len16 != 16'd0) begin
                            r_state <= ST_V2_PAY;
                        end else begin
                            r_state <= ST_V2_CHK;
                        end
                    end
                    ST_V1_PAY, ST_V2_PAY: begin
                        r_count <= n_count;
                        r_check <= n_check;
                        if (n_count >= r_len) begin
                            r_state <= (r_state == ST_V1_PAY) ? ST_V1_CHK : ST_V2_CHK;
                        end
                    end
                    ST_V1_CHK, ST_V2_CHK: begin
                        r_state <= ST_IDLE;
                        if (i_rx_byte == r_check) r_desc_vld <= 1'b1;
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // checked frame header
    assign o_desc_vld       = r_desc_vld;
    assign o_desc.version   = r_version;
    assign o_desc.direction = r_dir;
    assign o_desc.flag      = r_flag;
    assign o_desc.code      = r_code;
    assign o_desc.length    = r_len;

endmodule

@@ src/msp_back.sv @@
// ----------------------------------------------------------------------------
// msp_back
// Frame emitter: walks the payload buffer of a checked frame and fills a
// small result queue, one word per payload byte (one word when the length is zero).
// ----------------------------------------------------------------------------
module msp_back #(
    parameter int AW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_desc_vld,
    input  logic [msp_pkg::LEN_W-1:0] i_length,
    output logic                      o_take,
    output logic                      o_busy,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    input  logic [7:0]                i_rdata,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [msp_pkg::IDX_W-1:0] o_byte_index,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last_of_frame
);
    import msp_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             last;
    } t_res;

    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    logic               r_active;
    logic               r_issuing;
    logic [LEN_W-1:0]   r_k;
    logic               r_pend;
    logic               r_pend_zero;
    logic               r_pend_last;
    logic [IDX_W-1:0]   r_pend_idx;
    t_res               r_q [QD];
    logic [QA-1:0]      r_wp;
    logic [QA-1:0]      r_rp;
    logic [QA:0]        r_cnt;

    logic [LEN_W-1:0]   w_n;
    logic               w_issue;
    logic               w_pop;
    logic               w_last;
    logic [QA:0]        n_cnt;

    // words in this frame, one even when the length is zero
    assign w_n     = (i_length == '0) ? LEN_W'(1) : i_length;
    assign w_last  = (r_k + LEN_W'(1)) == w_n;
    assign w_issue = r_issuing && ((r_cnt + {{QA{1'b0}}, r_pend}) <= (QA+1)'(QD - 2));
    assign w_pop   = i_pop && (r_cnt != '0);
    assign n_cnt   = r_cnt + {{QA{1'b0}}, r_pend} - {{QA{1'b0}}, w_pop};
    assign o_take  = !r_active && i_desc_vld;
    assign o_busy  = r_active;

    // buffer read request
    assign o_re    = w_issue;
    assign o_raddr = r_k[AW-1:0];

    // emitter control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            if (o_take) begin
                r_active  <= 1'b1;
                r_issuing <= 1'b1;
                r_k       <= '0;
            end
            r_pend <= w_issue;
            if (w_issue) begin
                r_pend_idx  <= r_k[IDX_W-1:0];
                r_pend_zero <= (i_length == '0);
                r_pend_last <= w_last;
                r_k         <= r_k + LEN_W'(1);
                if (w_last) r_issuing <= 1'b0;
            end
            if (r_pend) begin
                r_q[r_wp] <= '{idx: r_pend_idx,
                               data: (r_pend_zero ? 8'd0 : i_rdata),
                               last: r_pend_last};
                r_wp <= r_wp + QA'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QA'(1);
                if (r_q[r_rp].last) r_active <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    // head of the result queue
    assign o_empty         = (r_cnt == '0);
    assign o_byte_index    = r_q[r_rp].idx;
    assign o_payload_byte  = r_q[r_rp].data;
    assign o_last_of_frame = r_q[r_rp].last;

endmodule

@@ src/msp_stream_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// msp_stream_frame_parser_core
// MSP version 1 / version 2 frame parser over a received byte stream.
// ----------------------------------------------------------------------------
// Input channel: one received word per accepted push (push high, full low).
// Output channel: a queue; while empty is low the oldest result is on the
// o_ ports and pop takes it. Each checked frame yields one result per payload
// byte (one result with byte 0 when the length is zero), the last one marked.
// Throughput: one input word per cycle while the parser is open. Each accepted
// word steps the byte state machine; the check byte posts the frame
// header into a one-entry hand-off slot.
// Output: the emitter takes the posted header, reads the payload buffer and
// writes each word into the result queue; then one result per cycle while
// pop stays high, fed by the buffer read port and a four-word result queue.
// Intake: full stays high from the check byte of a good frame until its last
// result is popped, as the payload buffer holds one frame. A stalled receiver
// only stretches that window; nothing is lost.
// Reset: parser returns to hunting for '$', queue empties. The payload buffer
// is not cleared; only entries written within the current frame are read.
// ----------------------------------------------------------------------------
module msp_stream_frame_parser_core #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       pop,
    output logic                       empty,
    output logic                       o_proto_version,
    output logic [7:0]                 o_direction,
    output logic [7:0]                 o_frame_flag,
    output logic [msp_pkg::CODE_W-1:0] o_message_code,
    output logic [msp_pkg::LEN_W-1:0]  o_payload_length,
    output logic [msp_pkg::IDX_W-1:0]  o_byte_index,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_last_of_frame
);
    import msp_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_frame           w_desc;
    logic             w_desc_vld;
    logic             w_take;
    logic             w_busy;
    logic             w_accept;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [7:0]       w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [7:0]       w_rdata;

    // intake closes while a frame waits or is being emitted
    assign full     = w_desc_vld || w_busy;
    assign w_accept = push && !full;

    // byte recognizer
    msp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_desc     (w_desc),
        .o_desc_vld (w_desc_vld),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata)
    );

    // payload buffer
    msp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // frame emitter
    msp_back #(
        .AW (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desc_vld      (w_desc_vld),
        .i_length        (w_desc.length),
        .o_take          (w_take),
        .o_busy          (w_busy),
        .o_re            (w_re),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_byte_index    (o_byte_index),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame)
    );

    // header fields stay put while the frame is emitted
    assign o_proto_version  = w_desc.version;
    assign o_direction      = w_desc.direction;
    assign o_frame_flag     = w_desc.flag;
    assign o_message_code   = w_desc.code;
    assign o_payload_length = w_desc.length;

    // hand-off slot and emitter never hold a frame at once
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_desc_vld && w_busy))
        else $error("frame posted while emitter busy");

    // buffer is not written while a frame is being emitted
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && (w_busy || w_desc_vld)))
        else $error("payload buffer written during emission");

    // popping the last word leaves the result queue empty
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_of_frame) |=> empty)
        else $error("result after last word of frame");

    // a shown result never carries an oversize length
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_payload_length <= LEN_W'(MAX_PAYLOAD)))
        else $error("payload length out of range");

endmodule
